FILE: sv/assert_macros.svh
// Assertion macros shared by the luminance alpha composer RTL.
// Standalone header; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/lac_pkg.sv
// Package for the luminance alpha composer: widths, luma weights,
// register indexes and the divider stage payload type. No dependencies.
package lac_pkg;

  localparam int unsigned NCH   = 3;   // color channels
  localparam int unsigned LUM_W = 24;  // luminance, 16-bit fraction
  localparam int unsigned REM_W = 32;  // divider remainder
  localparam int unsigned QUO_W = 8;   // quotient bits
  localparam int unsigned CN_W  = 16;  // color times 255
  localparam int unsigned SH_W  = $clog2(QUO_W);

  // Luma weights 0.3 / 0.59 / 0.11 over 65536
  localparam logic [LUM_W-1:0] LUMA_W0   = 24'd19661;
  localparam logic [LUM_W-1:0] LUMA_W1   = 24'd38666;
  localparam logic [LUM_W-1:0] LUMA_W2   = 24'd7209;
  localparam logic [LUM_W-1:0] LUMA_FULL = 24'd16711680;  // 255 * 65536

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEMULTIPLY   = 1'b1;

  typedef logic [7:0] pix_t;

  // Payload carried through the restoring divider stages
  typedef struct packed {
    logic [NCH-1:0][7:0]       color;
    logic [LUM_W-1:0]          lum;
    logic [NCH-1:0][REM_W-1:0] rem;
    logic [NCH-1:0][QUO_W-1:0] quo;
    logic [NCH-1:0]            sat;
    logic                      bypass;
  } div_t;

endpackage

FILE: sv/lac_if.sv
// Valid/ready stream interfaces for the pixel input and result channels.
// Standalone; field widths are fixed byte lanes.
interface lac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_byte0;
  logic [7:0] color_byte1;
  logic [7:0] color_byte2;
  logic [7:0] mask_byte0;
  logic [7:0] mask_byte1;
  logic [7:0] mask_byte2;

  modport source (output valid, color_byte0, color_byte1, color_byte2,
                  mask_byte0, mask_byte1, mask_byte2, input ready);
  modport sink   (input valid, color_byte0, color_byte1, color_byte2,
                  mask_byte0, mask_byte1, mask_byte2, output ready);
endinterface

interface lac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_alpha;

  modport source (output valid, out_byte0, out_byte1, out_byte2, out_alpha,
                  input ready);
  modport sink   (input valid, out_byte0, out_byte1, out_byte2, out_alpha,
                  output ready);
endinterface

FILE: sv/lac_div_step.sv
// One registered step of the restoring divider: one quotient bit per channel.
// Depends on lac_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lac_div_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lac_pkg::SH_W-1:0]  shift_amt,
  input  logic                      up_valid,
  input  lac_pkg::div_t             up_data,
  output logic                      up_ready,
  output logic                      dn_valid,
  output lac_pkg::div_t             dn_data,
  input  logic                      dn_ready
);
  import lac_pkg::*;

  logic             v_r;
  div_t             q_r;
  div_t             q_nxt;
  logic [REM_W-1:0] div_sh;
  logic [REM_W-1:0] div_sh_r;

  // Stage moves when empty or when downstream takes its transaction
  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = q_r;

  // Compare-subtract against the divisor shifted to this bit
  always_comb begin
    q_nxt  = up_data;
    div_sh = REM_W'(up_data.lum) << shift_amt;
    for (int k = 0; k < NCH; k++) begin
      if (up_data.rem[k] >= div_sh) begin
        q_nxt.rem[k]            = up_data.rem[k] - div_sh;
        q_nxt.quo[k][shift_amt] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      q_r <= q_nxt;
    end
  end

  // Divisor at this bit, for the remainder bound checks
  assign div_sh_r = REM_W'(q_r.lum) << shift_amt;

  `ASSERT_IMPLY(a_rem_bound0, clk, rst_n, v_r && !q_r.bypass && !q_r.sat[0], q_r.rem[0] < div_sh_r)
  `ASSERT_IMPLY(a_rem_bound1, clk, rst_n, v_r && !q_r.bypass && !q_r.sat[1], q_r.rem[1] < div_sh_r)
  `ASSERT_IMPLY(a_rem_bound2, clk, rst_n, v_r && !q_r.bypass && !q_r.sat[2], q_r.rem[2] < div_sh_r)

endmodule

FILE: sv/luminance_alpha_composer_unit.sv
// Luminance to alpha with optional unpremultiply, fully pipelined.
// 12 register stages: 3 front stages, 8 divider steps, output register.
// One pixel per clock while the result channel does not stall.
// The 8-bit restoring divider, one quotient bit per stage, sets the depth.
// rst_n is synchronous: it empties the pipeline and clears both registers.
// Depends on lac_pkg, lac_if.sv, lac_div_step and assert_macros.svh.
`include "assert_macros.svh"

module luminance_alpha_composer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lac_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lac_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lac_in_if.sink                         in_px,
  lac_out_if.source                      out_px
);
  import lac_pkg::*;

  // Configuration registers
  logic inv_r;
  logic dem_r;

  // Stage A: weighted products
  logic                      sta_v_r;
  logic [NCH-1:0][7:0]       sta_color_r;
  logic [NCH-1:0][LUM_W-1:0] sta_prod_r;
  logic                      sta_inv_r;
  logic                      sta_dem_r;
  logic                      rdy_a;

  // Stage B: luminance sum and color times 255
  logic                      stb_v_r;
  logic [NCH-1:0][7:0]       stb_color_r;
  logic [LUM_W-1:0]          stb_lum_r;
  logic [LUM_W-1:0]          stb_lum_nxt;
  logic [LUM_W-1:0]          stb_sum;
  logic [NCH-1:0][CN_W-1:0]  stb_cn_r;
  logic                      stb_dem_r;
  logic                      rdy_b;

  // Stage C: divider setup
  logic                      stc_v_r;
  div_t                      stc_r;
  div_t                      stc_nxt;
  logic                      rdy_c;

  // Divider chain
  logic [QUO_W:0]            dv;
  div_t                      dd [QUO_W+1];
  logic [QUO_W:0]            dr;

  // Output register
  logic                      out_v_r;
  logic [NCH-1:0][7:0]       out_byte_r;
  logic [NCH-1:0][7:0]       out_byte_nxt;
  logic [7:0]                out_alpha_r;
  logic                      rdy_o;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
      dem_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_INVERT_ALPHA: inv_r <= cfg_wdata[0];
        CFG_DEMULTIPLY:   dem_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Ready chain: a stage loads when empty or when it is handed on
  assign rdy_o       = !out_v_r || out_px.ready;
  assign rdy_c       = !stc_v_r || dr[0];
  assign rdy_b       = !stb_v_r || rdy_c;
  assign rdy_a       = !sta_v_r || rdy_b;
  assign in_px.ready = rdy_a;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sta_v_r <= 1'b0;
      stb_v_r <= 1'b0;
      stc_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy_a) sta_v_r <= in_px.valid;
      if (rdy_b) stb_v_r <= sta_v_r;
      if (rdy_c) stc_v_r <= stb_v_r;
      if (rdy_o) out_v_r <= dv[QUO_W];
    end
  end

  // Stage A payload: one constant multiply per mask byte
  always_ff @(posedge clk) begin
    if (in_px.valid && rdy_a) begin
      sta_color_r[0] <= in_px.color_byte0;
      sta_color_r[1] <= in_px.color_byte1;
      sta_color_r[2] <= in_px.color_byte2;
      sta_prod_r[0]  <= LUM_W'(in_px.mask_byte0) * LUMA_W0;
      sta_prod_r[1]  <= LUM_W'(in_px.mask_byte1) * LUMA_W1;
      sta_prod_r[2]  <= LUM_W'(in_px.mask_byte2) * LUMA_W2;
      sta_inv_r      <= inv_r;
      sta_dem_r      <= dem_r;
    end
  end

  // Stage B: sum products, optional inversion
  always_comb begin
    stb_sum     = sta_prod_r[0] + sta_prod_r[1] + sta_prod_r[2];
    stb_lum_nxt = sta_inv_r ? (LUMA_FULL - stb_sum) : stb_sum;
  end

  always_ff @(posedge clk) begin
    if (sta_v_r && rdy_b) begin
      stb_color_r <= sta_color_r;
      stb_lum_r   <= stb_lum_nxt;
      stb_dem_r   <= sta_dem_r;
      for (int k = 0; k < NCH; k++) begin
        stb_cn_r[k] <= {sta_color_r[k], 8'h00} - {8'h00, sta_color_r[k]};
      end
    end
  end

  // Stage C: dividend, saturation check and bypass decision
  always_comb begin
    stc_nxt.color  = stb_color_r;
    stc_nxt.lum    = stb_lum_r;
    stc_nxt.quo    = '0;
    stc_nxt.bypass = !stb_dem_r || (stb_lum_r == '0);
    for (int k = 0; k < NCH; k++) begin
      stc_nxt.rem[k] = {stb_cn_r[k], 16'h0000};
      // c*255*65536 >= 256*S means a quotient above 255
      stc_nxt.sat[k] = {stb_cn_r[k], 8'h00} >= stb_lum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stb_v_r && rdy_c) begin
      stc_r <= stc_nxt;
    end
  end

  // Restoring divider, most significant quotient bit first
  assign dv[0] = stc_v_r;
  assign dd[0] = stc_r;
  assign dr[QUO_W] = rdy_o;

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    lac_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_amt (SH_W'(QUO_W - 1 - j)),
      .up_valid  (dv[j]),
      .up_data   (dd[j]),
      .up_ready  (dr[j]),
      .dn_valid  (dv[j+1]),
      .dn_data   (dd[j+1]),
      .dn_ready  (dr[j+1])
    );
  end

  // Result select: pass-through, saturate or quotient
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      if (dd[QUO_W].bypass) begin
        out_byte_nxt[k] = dd[QUO_W].color[k];
      end else if (dd[QUO_W].sat[k]) begin
        out_byte_nxt[k] = 8'hFF;
      end else begin
        out_byte_nxt[k] = dd[QUO_W].quo[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dv[QUO_W] && rdy_o) begin
      out_byte_r  <= out_byte_nxt;
      out_alpha_r <= dd[QUO_W].lum[LUM_W-1:LUM_W-8];
    end
  end

  assign out_px.valid     = out_v_r;
  assign out_px.out_byte0 = out_byte_r[0];
  assign out_px.out_byte1 = out_byte_r[1];
  assign out_px.out_byte2 = out_byte_r[2];
  assign out_px.out_alpha = out_alpha_r;

  `ASSERT_IMPLY(a_in_ready_empty, clk, rst_n, !sta_v_r, in_px.ready)
  `ASSERT_NEXT(a_front_hold, clk, rst_n, sta_v_r && !rdy_b, sta_v_r)
  `ASSERT_IMPLY(a_zero_bypass, clk, rst_n, stc_v_r && (stc_r.lum == '0), stc_r.bypass)

endmodule

FILE: tb/lac_checker.sv
`timescale 1ns / 1ps
// Scoreboard for luminance_alpha_composer_unit: watches the pixel and result
// channels and the register port, predicts each result and compares it.
// Depends on lac_pkg and the stream interfaces in lac_if.sv.
module lac_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lac_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lac_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lac_in_if                              in_px,
  lac_out_if                             out_px,
  output int                             fail_count,
  output int                             pending
);
  import lac_pkg::*;

  // lanes 0..2 are the color bytes, lane 3 the alpha byte
  typedef logic [3:0][7:0] pixel_result_t;

  logic          invert_on;
  logic          demul_on;
  pixel_result_t expected_px_q [$];
  pixel_result_t got;
  pixel_result_t want;
  int            mismatches = 0;
  string         field_names [4] = '{"out_byte0", "out_byte1", "out_byte2", "out_alpha"};

  assign fail_count = mismatches;
  assign pending    = expected_px_q.size();

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // c * 255 / luminance, clipped to a byte; zero luminance leaves c alone
  function automatic pix_t unpremultiply(input pix_t c, input logic [LUM_W-1:0] lum);
    logic [47:0] q;
    if (lum == '0) return c;
    q = (48'(c) * 48'(LUMA_FULL)) / 48'(lum);
    return (q > 48'd255) ? 8'hFF : q[7:0];
  endfunction

  function automatic pixel_result_t compose_pixel(input pix_t c0, c1, c2, m0, m1, m2,
                                                  input logic inv, dem);
    logic [31:0]   lum;
    pix_t          color [3];
    pixel_result_t r;
    lum = 32'(LUMA_W0) * 32'(m0) + 32'(LUMA_W1) * 32'(m1) + 32'(LUMA_W2) * 32'(m2);
    if (inv) lum = 32'(LUMA_FULL) - lum;
    color = '{c0, c1, c2};
    for (int k = 0; k < 3; k++) begin
      r[k] = dem ? unpremultiply(color[k], lum[LUM_W-1:0]) : color[k];
    end
    r[3] = lum[23:16];
    return r;
  endfunction

  // predict on input transactions, compare on result transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      invert_on = 1'b0;
      demul_on  = 1'b0;
      expected_px_q.delete();
    end else begin
      if (in_px.valid && in_px.ready)
        expected_px_q.push_back(compose_pixel(in_px.color_byte0, in_px.color_byte1,
                                              in_px.color_byte2, in_px.mask_byte0,
                                              in_px.mask_byte1, in_px.mask_byte2,
                                              invert_on, demul_on));
      if (out_px.valid && out_px.ready) begin
        got = {out_px.out_alpha, out_px.out_byte2, out_px.out_byte1, out_px.out_byte0};
        if (expected_px_q.size() == 0) begin
          report($sformatf("result %h with nothing expected", got));
        end else begin
          want = expected_px_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k])
              report($sformatf("%s got %h expected %h", field_names[k], got[k], want[k]));
          end
        end
      end
      // register writes take effect for later transactions
      if (cfg_we) begin
        case (cfg_idx)
          CFG_INVERT_ALPHA: invert_on = cfg_wdata[0];
          CFG_DEMULTIPLY:   demul_on  = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Top of the luminance_alpha_composer_unit testbench: clock, reset, pixel
// stimulus, result back-pressure, watchdog and verdict.
// Depends on lac_pkg, lac_if.sv, lac_checker and the unit itself.
module tb;
  import lac_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_LIMIT     = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_PIXELS   = 132;
  localparam int RANDOM_PHASES  = 8;

  typedef enum {RX_FREE, RX_EVERY_THIRD, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles = 0;
  int                    burst_left = 0;
  logic                  steady = 1'b0;
  logic                  hold_req = 1'b0;

  lac_in_if  in_px ();
  lac_out_if out_px ();

  luminance_alpha_composer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_px     (in_px),
    .out_px    (out_px)
  );

  lac_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_px      (in_px),
    .out_px     (out_px),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
      $display("luminance_alpha_composer_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure: segments of different stall patterns,
  // plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       seg_left;
    int       tick;
    mode = RX_FREE;
    seg_left = 0;
    tick = 0;
    out_px.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_px.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        tick++;
        case (mode)
          RX_FREE:        out_px.ready = 1'b1;
          RX_EVERY_THIRD: out_px.ready = (tick % 3) != 0;
          RX_COIN:        out_px.ready = 1'($urandom_range(0, 1));
          RX_SPARSE:      out_px.ready = ($urandom_range(0, 3) == 0);
          default:        out_px.ready = 1'b1;
        endcase
      end
    end
  end

  // one pixel transaction; the sender runs in bursts separated by gaps
  task automatic send_pixel(input pix_t c0, c1, c2, m0, m1, m2);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
      if (gap != 0) begin
        in_px.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_px.color_byte0 = c0;
    in_px.color_byte1 = c1;
    in_px.color_byte2 = c2;
    in_px.mask_byte0  = m0;
    in_px.mask_byte1  = m1;
    in_px.mask_byte2  = m2;
    in_px.valid       = 1'b1;
    do @(posedge clk); while (!in_px.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // wait until every predicted result has come back
  task automatic drain();
    in_px.valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_mode(input logic inv, input logic dem);
    drain();
    write_reg(CFG_INVERT_ALPHA, inv);
    write_reg(CFG_DEMULTIPLY, dem);
  endtask

  function automatic pix_t rand_color();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return pix_t'($urandom_range(0, 255));
  endfunction

  task automatic send_random_pixel();
    pix_t m [3];
    int   shape;
    shape = $urandom_range(0, 7);
    for (int k = 0; k < 3; k++) begin
      case (shape)
        0:       m[k] = 8'h00;
        1:       m[k] = 8'hFF;
        2:       m[k] = pix_t'($urandom_range(0, 3));
        3:       m[k] = pix_t'(8'hFF - $urandom_range(0, 2));
        default: m[k] = pix_t'($urandom_range(0, 255));
      endcase
    end
    send_pixel(rand_color(), rand_color(), rand_color(), m[0], m[1], m[2]);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_px.valid       = 1'b0;
    in_px.color_byte0 = '0;
    in_px.color_byte1 = '0;
    in_px.color_byte2 = '0;
    in_px.mask_byte0  = '0;
    in_px.mask_byte1  = '0;
    in_px.mask_byte2  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: plain pass-through, alpha from luminance
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hA5, 8'h5A, 8'h3C, 8'hFF, 8'h00, 8'h00);
    send_pixel(8'h01, 8'h80, 8'hFE, 8'h00, 8'hFF, 8'h00);
    send_pixel(8'h7F, 8'h40, 8'hC3, 8'h00, 8'h00, 8'hFF);

    // demultiply: zero luminance, full luminance, saturation
    set_mode(1'b0, 1'b1);
    send_pixel(8'd200, 8'd17, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h80, 8'h01, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00);
    send_pixel(8'd127, 8'd64, 8'd200, 8'd128, 8'd128, 8'd128);
    send_pixel(8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h01);

    // inverted luminance with demultiply: full mask gives zero luminance
    set_mode(1'b1, 1'b1);
    send_pixel(8'd9, 8'd99, 8'd199, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'd77, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'h10, 8'hFE, 8'hFF, 8'hFF);
    send_pixel(8'd33, 8'd150, 8'd240, 8'd100, 8'd50, 8'd200);

    // inverted alpha alone
    set_mode(1'b1, 1'b0);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hAA, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h0F, 8'hFF, 8'h00, 8'h00);

    // random phases over every register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_mode(p[1], p[0]);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        // one long result stall while pixels keep coming
        if (p == 3 && i == 40) begin
          hold_req = 1'b1;
          steady = 1'b1;
        end
        if (p == 3 && i == 120) steady = 1'b0;
        send_random_pixel();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("luminance_alpha_composer_unit regression: pass");
    end else begin
      $display("luminance_alpha_composer_unit regression: fail");
    end
    $finish;
  end

endmodule
